// ===== rtl/core/mcvm_pkg.sv =====
`default_nettype none
package mcvm_pkg;

   // Fixed-point formats.
   localparam int ANGLE_FRAC_BITS = 7;
   localparam int COEF_FRAC_BITS  = 8;

   // Field widths.
   localparam int MODE_W  = 3;
   localparam int VEL_W   = 16;
   localparam int COEF_W  = 16;
   localparam int LIMIT_W = 10;
   localparam int SCALE_W = 10;
   localparam int REF_W   = 24;
   localparam int GAIN_W  = 4;
   localparam int WHEELS  = 4;
   localparam int CSR_IDX_W = 2;

   // Shared multiplier operand widths (signed).
   localparam int MA_W   = 36;
   localparam int MB_W   = 34;
   localparam int PROD_W = MA_W + MB_W;

   // Yaw rate and wheel sum widths.
   localparam int YAW_W = 28;
   localparam int SUM_W = 62;

   // Angle reduction.
   localparam int FULL_TURN = 360 << ANGLE_FRAC_BITS;
   localparam int QUARTER   = 90 << ANGLE_FRAC_BITS;
   localparam int ANG_W     = $clog2(FULL_TURN) + 2;

   // Series evaluation: six sine terms followed by seven cosine terms.
   localparam int TERMS     = 13;
   localparam int SIN_TERMS = 6;
   localparam int TERM_W    = 4;
   localparam logic [30:0] ONE_Q30 = 31'h4000_0000;
   localparam logic [MB_W-1:0] DEG_TO_RAD_Q30 = MB_W'(18740330);

   // Output range.
   localparam int OUT_MAX = 8388607;
   localparam int OUT_MIN = -8388608;

   // Chassis modes.
   localparam logic [MODE_W-1:0] MODE_ZERO_FORCE = 3'd0;
   localparam logic [MODE_W-1:0] MODE_NO_FOLLOW  = 3'd1;
   localparam logic [MODE_W-1:0] MODE_FOLLOW     = 3'd2;
   localparam logic [MODE_W-1:0] MODE_SPIN       = 3'd3;

   // Spin gain selection, gain kept in halves.
   localparam logic [LIMIT_W-1:0] LIMIT_LOW  = 10'd60;
   localparam logic [LIMIT_W-1:0] LIMIT_MID  = 10'd80;
   localparam logic [LIMIT_W-1:0] LIMIT_HIGH = 10'd100;
   localparam logic [GAIN_W-1:0]  GAIN_LOW   = 4'd3;
   localparam logic [GAIN_W-1:0]  GAIN_MID   = 4'd4;
   localparam logic [GAIN_W-1:0]  GAIN_HIGH  = 4'd8;
   // Spin yaw rate is 3000 times the gain, so 1500 per half step.
   localparam logic [14:0] SPIN_RATE_PER_HALF = 15'd1500;

   // Configuration register indexes (also the wheel order).
   localparam logic [CSR_IDX_W-1:0] CSR_LF_COEF = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_RF_COEF = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_LB_COEF = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_RB_COEF = 2'd3;

   typedef struct packed {
      logic [MODE_W-1:0]       opcode;
      logic signed [VEL_W-1:0] speed_x;
      logic signed [VEL_W-1:0] speed_y;
      logic signed [VEL_W-1:0] yaw_rate_in;
      logic signed [VEL_W-1:0] gimbal_offset;
      logic [LIMIT_W-1:0]      power_limit;
      logic [SCALE_W-1:0]      power_scale;
   } req_word_type;

   typedef struct packed {
      logic signed [REF_W-1:0] left_front_ref;
      logic signed [REF_W-1:0] right_front_ref;
      logic signed [REF_W-1:0] left_back_ref;
      logic signed [REF_W-1:0] right_back_ref;
      logic                    motors_enabled;
   } rsp_word_type;

   typedef logic [WHEELS-1:0][COEF_W-1:0] coef_set_type;

   typedef enum logic [4:0] {
      ST_IDLE, ST_WRAP, ST_XMUL, ST_XSQ, ST_X2,
      ST_T0, ST_T1, ST_T2, ST_T3, ST_SFIN, ST_SCAP,
      ST_R0, ST_R1, ST_R2, ST_R3, ST_R4, ST_YAW,
      ST_M0, ST_M1, ST_M2, ST_M3, ST_DONE
   } state_type;

   // Divisor of each series step.
   function automatic logic [7:0] term_div(input logic [TERM_W-1:0] idx);
      logic [7:0] d;
      case (idx)
         4'd0:    d = 8'd156;
         4'd1:    d = 8'd110;
         4'd2:    d = 8'd72;
         4'd3:    d = 8'd42;
         4'd4:    d = 8'd20;
         4'd5:    d = 8'd6;
         4'd6:    d = 8'd182;
         4'd7:    d = 8'd132;
         4'd8:    d = 8'd90;
         4'd9:    d = 8'd56;
         4'd10:   d = 8'd30;
         4'd11:   d = 8'd12;
         default: d = 8'd2;
      endcase
      return d;
   endfunction

   // Reciprocal of each divisor, floor(2^32 / d).
   function automatic logic [31:0] term_recip(input logic [TERM_W-1:0] idx);
      logic [31:0] m;
      case (idx)
         4'd0:    m = 32'd27531841;
         4'd1:    m = 32'd39045157;
         4'd2:    m = 32'd59652323;
         4'd3:    m = 32'd102261126;
         4'd4:    m = 32'd214748364;
         4'd5:    m = 32'd715827882;
         4'd6:    m = 32'd23598721;
         4'd7:    m = 32'd32537631;
         4'd8:    m = 32'd47721858;
         4'd9:    m = 32'd76695844;
         4'd10:   m = 32'd143165576;
         4'd11:   m = 32'd357913941;
         default: m = 32'd2147483648;
      endcase
      return m;
   endfunction

   // Round a Q30 value half up to Q1.15 and cap at the largest code.
   function automatic logic signed [15:0] to_q15(input logic [30:0] v);
      logic [16:0] r;
      r = 17'((32'(v) + 32'h4000) >> 15);
      return (r > 17'd32767) ? 16'sd32767 : 16'(r);
   endfunction

   // Spin gain chosen by a power limit.
   function automatic logic [GAIN_W-1:0] gain_for_limit(input logic [LIMIT_W-1:0] lim);
      logic [GAIN_W-1:0] g;
      case (lim)
         LIMIT_LOW:  g = GAIN_LOW;
         LIMIT_MID:  g = GAIN_MID;
         LIMIT_HIGH: g = GAIN_HIGH;
         default:    g = GAIN_LOW;
      endcase
      return g;
   endfunction

endpackage
`default_nettype wire

// ===== rtl/core/mcvm_chan_if.sv =====
`default_nettype none
interface mcvm_chan_if #(
   parameter type payload_type = logic
) ();
   logic        valid;
   logic        ready;
   payload_type data;

   modport source(output valid, output data, input ready);
   modport sink(input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/mcvm_mul_unit.sv =====
`default_nettype none
module mcvm_mul_unit (
   input  wire logic                                  clock,
   input  wire logic [mcvm_pkg::MA_W-1:0]             op_a,
   input  wire logic [mcvm_pkg::MB_W-1:0]             op_b,
   output logic signed [mcvm_pkg::PROD_W-1:0]         prod
);
   logic signed [mcvm_pkg::PROD_W-1:0] prod_ff;

   // Signed product, registered every cycle.
   always_ff @(posedge clock) begin
      prod_ff <= $signed(op_a) * $signed(op_b);
   end

   assign prod = prod_ff;
endmodule
`default_nettype wire

// ===== rtl/core/mcvm_csr_regs.sv =====
`default_nettype none
module mcvm_csr_regs (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 csr_write_en,
   input  wire logic [mcvm_pkg::CSR_IDX_W-1:0]       csr_index,
   input  wire logic [mcvm_pkg::COEF_W-1:0]          csr_write_data,
   output mcvm_pkg::coef_set_type                    coefs
);
   localparam logic [mcvm_pkg::COEF_W-1:0] COEF_ONE =
      mcvm_pkg::COEF_W'(1 << mcvm_pkg::COEF_FRAC_BITS);

   mcvm_pkg::coef_set_type coef_ff;
   mcvm_pkg::coef_set_type coef_in;

   // Register decode.
   always_comb begin
      coef_in = coef_ff;
      if (csr_write_en) begin
         unique case (csr_index)
            mcvm_pkg::CSR_LF_COEF: coef_in[0] = csr_write_data;
            mcvm_pkg::CSR_RF_COEF: coef_in[1] = csr_write_data;
            mcvm_pkg::CSR_LB_COEF: coef_in[2] = csr_write_data;
            mcvm_pkg::CSR_RB_COEF: coef_in[3] = csr_write_data;
            default: coef_in = coef_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         coef_ff <= {mcvm_pkg::WHEELS{COEF_ONE}};
      end else begin
         coef_ff <= coef_in;
      end
   end

   assign coefs = coef_ff;
endmodule
`default_nettype wire

// ===== rtl/core/mcvm_engine.sv =====
`default_nettype none
module mcvm_engine (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  req_valid,
   output logic                                       req_ready,
   input  wire mcvm_pkg::req_word_type                req_word,
   input  wire mcvm_pkg::coef_set_type                coefs,
   output logic                                       res_valid,
   input  wire logic                                  res_take,
   output mcvm_pkg::rsp_word_type                     res_word,
   output logic [mcvm_pkg::MA_W-1:0]                  mul_a,
   output logic [mcvm_pkg::MB_W-1:0]                  mul_b,
   input  wire logic signed [mcvm_pkg::PROD_W-1:0]    prod
);
   localparam int A     = mcvm_pkg::ANGLE_FRAC_BITS;
   localparam int AW    = mcvm_pkg::ANG_W;
   localparam int WW    = mcvm_pkg::YAW_W;
   localparam int SW    = mcvm_pkg::SUM_W;
   localparam int PW    = mcvm_pkg::PROD_W;
   localparam int LIN_SHIFT = mcvm_pkg::ANGLE_FRAC_BITS + mcvm_pkg::COEF_FRAC_BITS;
   localparam int Q8_SHIFT  = 15 + LIN_SHIFT - 8;
   localparam logic signed [AW-1:0] FULL_S    = AW'(mcvm_pkg::FULL_TURN);
   localparam logic signed [AW-1:0] QUARTER_S = AW'(mcvm_pkg::QUARTER);
   localparam logic signed [SW-1:0] Q8_RND    = SW'(1) <<< (Q8_SHIFT - 1);
   localparam logic signed [PW-1:0] OUT_RND   = PW'(32768);
   localparam logic signed [PW-1:0] OUT_MAX_S = PW'(mcvm_pkg::OUT_MAX);
   localparam logic signed [PW-1:0] OUT_MIN_S = PW'(mcvm_pkg::OUT_MIN);

   mcvm_pkg::state_type state_ff, state_in;

   logic [mcvm_pkg::MODE_W-1:0]        mode_ff, mode_in;
   logic signed [15:0]                 vx_ff, vx_in, vy_ff, vy_in;
   logic signed [15:0]                 yin_ff, yin_in, g_ff, g_in;
   logic [mcvm_pkg::LIMIT_W-1:0]       limit_ff, limit_in;
   logic [mcvm_pkg::SCALE_W-1:0]       scale_ff, scale_in;
   logic [mcvm_pkg::GAIN_W-1:0]        gain_ff, gain_in;
   logic signed [AW-1:0]               ang_ff, ang_in;
   logic [1:0]                         quad_ff, quad_in;
   logic [30:0]                        x_ff, x_in;
   logic [31:0]                        x2_ff, x2_in;
   logic [30:0]                        ts_ff, ts_in, sts_ff, sts_in;
   logic [31:0]                        p_ff, p_in;
   logic [30:0]                        qt_ff, qt_in;
   logic [mcvm_pkg::TERM_W-1:0]        term_ff, term_in;
   logic signed [15:0]                 sn_ff, sn_in, cs_ff, cs_in;
   logic signed [32:0]                 rx_ff, rx_in, ry_ff, ry_in;
   logic signed [WW-1:0]               w_ff, w_in;
   logic signed [mcvm_pkg::MA_W-1:0]   q8_ff, q8_in;
   logic [1:0]                         wheel_ff, wheel_in;
   logic [mcvm_pkg::WHEELS-1:0][mcvm_pkg::REF_W-1:0] wref_ff, wref_in;

   logic                               wrap_done;
   logic [16:0]                        mag;
   logic [16-A:0]                      deg;
   logic [32:0]                        rem;
   logic [31:0]                        qn;
   logic [30:0]                        ts_new;
   logic signed [15:0]                 s0, c0;
   logic signed [33:0]                 lin;
   logic signed [SW-1:0]               ysum, wsum;
   logic signed [PW-1:0]               vround;

   // Angle is reduced once it is non-negative and inside the first quadrant.
   assign wrap_done = !ang_ff[AW-1] && (ang_ff < QUARTER_S);
   assign mag = g_ff[15] ? 17'(-$signed({g_ff[15], g_ff})) : 17'({1'b0, g_ff});
   assign deg = mag[16:A];

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         mcvm_pkg::ST_IDLE: if (req_valid) state_in = mcvm_pkg::ST_WRAP;
         mcvm_pkg::ST_WRAP: if (wrap_done) state_in = mcvm_pkg::ST_XMUL;
         mcvm_pkg::ST_XMUL: state_in = mcvm_pkg::ST_XSQ;
         mcvm_pkg::ST_XSQ:  state_in = mcvm_pkg::ST_X2;
         mcvm_pkg::ST_X2:   state_in = mcvm_pkg::ST_T0;
         mcvm_pkg::ST_T0:   state_in = mcvm_pkg::ST_T1;
         mcvm_pkg::ST_T1:   state_in = mcvm_pkg::ST_T2;
         mcvm_pkg::ST_T2:   state_in = mcvm_pkg::ST_T3;
         mcvm_pkg::ST_T3: begin
            if (term_ff == mcvm_pkg::TERM_W'(mcvm_pkg::TERMS - 1)) begin
               state_in = mcvm_pkg::ST_SFIN;
            end else begin
               state_in = mcvm_pkg::ST_T0;
            end
         end
         mcvm_pkg::ST_SFIN: state_in = mcvm_pkg::ST_SCAP;
         mcvm_pkg::ST_SCAP: state_in = mcvm_pkg::ST_R0;
         mcvm_pkg::ST_R0:   state_in = mcvm_pkg::ST_R1;
         mcvm_pkg::ST_R1:   state_in = mcvm_pkg::ST_R2;
         mcvm_pkg::ST_R2:   state_in = mcvm_pkg::ST_R3;
         mcvm_pkg::ST_R3:   state_in = mcvm_pkg::ST_R4;
         mcvm_pkg::ST_R4:   state_in = mcvm_pkg::ST_YAW;
         mcvm_pkg::ST_YAW:  state_in = mcvm_pkg::ST_M0;
         mcvm_pkg::ST_M0:   state_in = mcvm_pkg::ST_M1;
         mcvm_pkg::ST_M1:   state_in = mcvm_pkg::ST_M2;
         mcvm_pkg::ST_M2:   state_in = mcvm_pkg::ST_M3;
         mcvm_pkg::ST_M3: begin
            if (wheel_ff == 2'd3) begin
               state_in = mcvm_pkg::ST_DONE;
            end else begin
               state_in = mcvm_pkg::ST_M0;
            end
         end
         mcvm_pkg::ST_DONE: if (res_take) state_in = mcvm_pkg::ST_IDLE;
         default: state_in = mcvm_pkg::ST_IDLE;
      endcase
   end

   // Handshake outputs and operands of the shared multiplier.
   always_comb begin
      req_ready = 1'b0;
      res_valid = 1'b0;
      mul_a     = '0;
      mul_b     = '0;
      unique case (state_ff)
         mcvm_pkg::ST_IDLE: req_ready = 1'b1;
         mcvm_pkg::ST_XMUL: begin
            mul_a = mcvm_pkg::MA_W'(ang_ff);
            mul_b = mcvm_pkg::DEG_TO_RAD_Q30;
         end
         mcvm_pkg::ST_XSQ: begin
            mul_a = mcvm_pkg::MA_W'(prod[A+30:A]);
            mul_b = mcvm_pkg::MB_W'(prod[A+30:A]);
         end
         mcvm_pkg::ST_T0: begin
            mul_a = mcvm_pkg::MA_W'(x2_ff);
            mul_b = mcvm_pkg::MB_W'(ts_ff);
         end
         mcvm_pkg::ST_T1: begin
            mul_a = mcvm_pkg::MA_W'(prod[61:30]);
            mul_b = mcvm_pkg::MB_W'(mcvm_pkg::term_recip(term_ff));
         end
         mcvm_pkg::ST_T2: begin
            mul_a = mcvm_pkg::MA_W'(prod[62:32]);
            mul_b = mcvm_pkg::MB_W'(mcvm_pkg::term_div(term_ff));
         end
         mcvm_pkg::ST_SFIN: begin
            mul_a = mcvm_pkg::MA_W'(x_ff);
            mul_b = mcvm_pkg::MB_W'(sts_ff);
         end
         mcvm_pkg::ST_R0: begin
            mul_a = mcvm_pkg::MA_W'(vx_ff);
            mul_b = mcvm_pkg::MB_W'(cs_ff);
         end
         mcvm_pkg::ST_R1: begin
            mul_a = mcvm_pkg::MA_W'(vy_ff);
            mul_b = mcvm_pkg::MB_W'(sn_ff);
         end
         mcvm_pkg::ST_R2: begin
            mul_a = mcvm_pkg::MA_W'(vx_ff);
            mul_b = mcvm_pkg::MB_W'(sn_ff);
         end
         mcvm_pkg::ST_R3: begin
            mul_a = mcvm_pkg::MA_W'(vy_ff);
            mul_b = mcvm_pkg::MB_W'(cs_ff);
         end
         mcvm_pkg::ST_R4: begin
            mul_a = mcvm_pkg::MA_W'(g_ff);
            mul_b = mcvm_pkg::MB_W'(deg);
         end
         mcvm_pkg::ST_M0: begin
            mul_a = mcvm_pkg::MA_W'(w_ff);
            mul_b = mcvm_pkg::MB_W'($signed(coefs[wheel_ff]));
         end
         mcvm_pkg::ST_M2: begin
            mul_a = mcvm_pkg::MA_W'(q8_ff);
            mul_b = mcvm_pkg::MB_W'(scale_ff);
         end
         mcvm_pkg::ST_DONE: res_valid = 1'b1;
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   // Series step: floor division by reciprocal with one correction.
   always_comb begin
      rem    = {1'b0, p_ff} - 33'(prod[32:0]);
      qn     = {1'b0, qt_ff} + 32'(rem >= 33'(mcvm_pkg::term_div(term_ff)));
      ts_new = (qn > 32'(mcvm_pkg::ONE_Q30)) ? '0 : 31'(32'(mcvm_pkg::ONE_Q30) - qn);
      s0     = mcvm_pkg::to_q15(prod[60:30]);
      c0     = mcvm_pkg::to_q15(ts_ff);
   end

   // Wheel sum for the current wheel, rounded to Q8.
   always_comb begin
      if (wheel_ff == 2'd0 || wheel_ff == 2'd3) begin
         lin = 34'(rx_ff) + 34'(ry_ff);
      end else begin
         lin = 34'(ry_ff) - 34'(rx_ff);
      end
      ysum = SW'(prod) <<< 15;
      if (wheel_ff[0]) begin
         wsum = (SW'(lin) <<< LIN_SHIFT) - ysum;
      end else begin
         wsum = (SW'(lin) <<< LIN_SHIFT) + ysum;
      end
      vround = (prod + OUT_RND) >>> 16;
   end

   // Datapath register updates.
   always_comb begin
      mode_in  = mode_ff;
      vx_in    = vx_ff;
      vy_in    = vy_ff;
      yin_in   = yin_ff;
      g_in     = g_ff;
      limit_in = limit_ff;
      scale_in = scale_ff;
      gain_in  = gain_ff;
      ang_in   = ang_ff;
      quad_in  = quad_ff;
      x_in     = x_ff;
      x2_in    = x2_ff;
      ts_in    = ts_ff;
      sts_in   = sts_ff;
      p_in     = p_ff;
      qt_in    = qt_ff;
      term_in  = term_ff;
      sn_in    = sn_ff;
      cs_in    = cs_ff;
      rx_in    = rx_ff;
      ry_in    = ry_ff;
      w_in     = w_ff;
      q8_in    = q8_ff;
      wheel_in = wheel_ff;
      wref_in  = wref_ff;
      unique case (state_ff)
         mcvm_pkg::ST_IDLE: begin
            if (req_valid) begin
               mode_in  = req_word.opcode;
               vx_in    = req_word.speed_x;
               vy_in    = req_word.speed_y;
               yin_in   = req_word.yaw_rate_in;
               g_in     = req_word.gimbal_offset;
               limit_in = req_word.power_limit;
               scale_in = req_word.power_scale;
               ang_in   = AW'(req_word.gimbal_offset);
               quad_in  = 2'd0;
            end
         end
         mcvm_pkg::ST_WRAP: begin
            if (ang_ff[AW-1]) begin
               ang_in = ang_ff + FULL_S;
            end else if (ang_ff >= FULL_S) begin
               ang_in = ang_ff - FULL_S;
            end else if (ang_ff >= QUARTER_S) begin
               ang_in  = ang_ff - QUARTER_S;
               quad_in = quad_ff + 2'd1;
            end
         end
         mcvm_pkg::ST_XSQ: x_in = prod[A+30:A];
         mcvm_pkg::ST_X2: begin
            x2_in   = prod[61:30];
            ts_in   = mcvm_pkg::ONE_Q30;
            term_in = '0;
         end
         mcvm_pkg::ST_T1: p_in = prod[61:30];
         mcvm_pkg::ST_T2: qt_in = prod[62:32];
         mcvm_pkg::ST_T3: begin
            term_in = term_ff + 1'b1;
            if (term_ff == mcvm_pkg::TERM_W'(mcvm_pkg::SIN_TERMS - 1)) begin
               sts_in = ts_new;
               ts_in  = mcvm_pkg::ONE_Q30;
            end else begin
               ts_in = ts_new;
            end
         end
         mcvm_pkg::ST_SCAP: begin
            case (quad_ff)
               2'd0: begin sn_in = s0;  cs_in = c0;  end
               2'd1: begin sn_in = c0;  cs_in = -s0; end
               2'd2: begin sn_in = -s0; cs_in = -c0; end
               default: begin sn_in = -c0; cs_in = s0; end
            endcase
         end
         mcvm_pkg::ST_R1: rx_in = 33'(prod);
         mcvm_pkg::ST_R2: rx_in = rx_ff - 33'(prod);
         mcvm_pkg::ST_R3: ry_in = 33'(prod);
         mcvm_pkg::ST_R4: ry_in = ry_ff + 33'(prod);
         mcvm_pkg::ST_YAW: begin
            case (mode_ff)
               mcvm_pkg::MODE_NO_FOLLOW: w_in = '0;
               mcvm_pkg::MODE_FOLLOW:    w_in = -(WW'(prod) <<< 1);
               mcvm_pkg::MODE_SPIN: begin
                  w_in = WW'({1'b0, 15'(gain_ff * mcvm_pkg::SPIN_RATE_PER_HALF)}) <<< A;
               end
               default: w_in = WW'(yin_ff) <<< A;
            endcase
            wheel_in = 2'd0;
         end
         mcvm_pkg::ST_M1: q8_in = mcvm_pkg::MA_W'((wsum + Q8_RND) >>> Q8_SHIFT);
         mcvm_pkg::ST_M3: begin
            if (vround > OUT_MAX_S) begin
               wref_in[wheel_ff] = mcvm_pkg::REF_W'(OUT_MAX_S);
            end else if (vround < OUT_MIN_S) begin
               wref_in[wheel_ff] = mcvm_pkg::REF_W'(OUT_MIN_S);
            end else begin
               wref_in[wheel_ff] = mcvm_pkg::REF_W'(vround);
            end
            wheel_in = wheel_ff + 2'd1;
         end
         mcvm_pkg::ST_DONE: begin
            if (res_take) gain_in = mcvm_pkg::gain_for_limit(limit_ff);
         end
         default: ;
      endcase
   end

   // Sequencer state and the spin gain carried from one command to the next.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= mcvm_pkg::ST_IDLE;
         gain_ff  <= '0;
      end else begin
         state_ff <= state_in;
         gain_ff  <= gain_in;
      end
   end

   always_ff @(posedge clock) begin
      mode_ff  <= mode_in;
      vx_ff    <= vx_in;
      vy_ff    <= vy_in;
      yin_ff   <= yin_in;
      g_ff     <= g_in;
      limit_ff <= limit_in;
      scale_ff <= scale_in;
      ang_ff   <= ang_in;
      quad_ff  <= quad_in;
      x_ff     <= x_in;
      x2_ff    <= x2_in;
      ts_ff    <= ts_in;
      sts_ff   <= sts_in;
      p_ff     <= p_in;
      qt_ff    <= qt_in;
      term_ff  <= term_in;
      sn_ff    <= sn_in;
      cs_ff    <= cs_in;
      rx_ff    <= rx_in;
      ry_ff    <= ry_in;
      w_ff     <= w_in;
      q8_ff    <= q8_in;
      wheel_ff <= wheel_in;
      wref_ff  <= wref_in;
   end

   // Result word.
   assign res_word.left_front_ref  = wref_ff[0];
   assign res_word.right_front_ref = wref_ff[1];
   assign res_word.left_back_ref   = wref_ff[2];
   assign res_word.right_back_ref  = wref_ff[3];
   assign res_word.motors_enabled  = (mode_ff != mcvm_pkg::MODE_ZERO_FORCE);
endmodule
`default_nettype wire

// ===== rtl/core/mecanum_chassis_velocity_mixer_core.sv =====
`default_nettype none
// Channel  Dir  Ports                          Carries
// req      in   req_if.valid/ready/data        one chassis command word
// rsp      out  rsp_if.valid/ready/data        four wheel references and enable
// csr      in   csr_write_en/index/write_data  yaw coefficient writes
//
// Each command word is worked in order through the single shared multiplier, from
// acceptance to the next ready: one to five angle reduction steps, thirteen series
// steps for sine and cosine, then rotation and mixing.
// The block takes no new word while one is in work; a finished word waits in the
// output register, so the next command is accepted while it is still not taken.
// Reset is synchronous, active high; coefficients return to 1.0, spin gain to 0.
module mecanum_chassis_velocity_mixer_core (
   input  wire logic                               clock,
   input  wire logic                               reset,
   mcvm_chan_if.sink                               req_if,
   mcvm_chan_if.source                             rsp_if,
   input  wire logic                               csr_write_en,
   input  wire logic [mcvm_pkg::CSR_IDX_W-1:0]     csr_index,
   input  wire logic [mcvm_pkg::COEF_W-1:0]        csr_write_data
);
   mcvm_pkg::coef_set_type             coefs;
   mcvm_pkg::rsp_word_type             res_word;
   mcvm_pkg::rsp_word_type             rsp_data_ff;
   logic                               rsp_valid_ff;
   logic                               res_valid;
   logic                               res_take;
   logic                               req_ready;
   logic [mcvm_pkg::MA_W-1:0]          mul_a;
   logic [mcvm_pkg::MB_W-1:0]          mul_b;
   logic signed [mcvm_pkg::PROD_W-1:0] prod;

   mcvm_csr_regs u_csr (
      .clock          (clock),
      .reset          (reset),
      .csr_write_en   (csr_write_en),
      .csr_index      (csr_index),
      .csr_write_data (csr_write_data),
      .coefs          (coefs)
   );

   mcvm_mul_unit u_mul (
      .clock (clock),
      .op_a  (mul_a),
      .op_b  (mul_b),
      .prod  (prod)
   );

   mcvm_engine u_engine (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_ready (req_ready),
      .req_word  (req_if.data),
      .coefs     (coefs),
      .res_valid (res_valid),
      .res_take  (res_take),
      .res_word  (res_word),
      .mul_a     (mul_a),
      .mul_b     (mul_b),
      .prod      (prod)
   );

   // Output register: load when empty or being drained.
   assign res_take = res_valid && (!rsp_valid_ff || rsp_if.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (res_take) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_if.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (res_take) begin
         rsp_data_ff <= res_word;
      end
   end

   assign req_if.ready = req_ready;
   assign rsp_if.valid = rsp_valid_ff;
   assign rsp_if.data  = rsp_data_ff;
endmodule
`default_nettype wire
